// ----- sv/flpks_pkg.sv -----
package flpks_pkg;

  localparam int SlotCount  = 1024;
  localparam int BloomWords = 512;
  localparam int SlotAw     = $clog2(SlotCount);
  localparam int BloomAw    = (BloomWords > 1) ? $clog2(BloomWords) : 1;
  localparam int CountW     = 11;
  localparam int QueueDepth = 2;
  localparam logic [63:0] MixMult = 64'hd6e8feb86659fd93;
  // refuse when (count + 1) * 10 >= SlotCount * 7
  localparam logic [CountW:0] FullLimit = (CountW + 1)'((SlotCount * 7 + 9) / 10 - 1);

  localparam logic FuncLookup = 1'b0;
  localparam logic FuncInsert = 1'b1;

  typedef struct packed {
    logic        func;
    logic [63:0] key;
  } in_word_t;

  typedef struct packed {
    logic              present;
    logic              added;
    logic              filter_pass;
    logic              table_full;
    logic [CountW-1:0] entry_count;
  } out_word_t;

  // classified item handed from front to back
  typedef struct packed {
    logic              func;
    logic [63:0]       key;
    logic [SlotAw-1:0] slot;
    logic [BloomAw-1:0] bword;
    logic [63:0]       bmask;
  } job_t;

  typedef enum logic [2:0] {
    BK_CLEAR, BK_IDLE, BK_BREAD, BK_PROBE, BK_WRITE, BK_DONE
  } back_state_t;

  typedef enum logic [1:0] {
    FR_IDLE, FR_MUL, FR_MIX
  } front_state_t;

endpackage

// ----- sv/flpks_front.sv -----
module flpks_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  flpks_pkg::in_word_t in_data,
  output logic                job_valid,
  input  logic                job_ready,
  output flpks_pkg::job_t     job
);
  import flpks_pkg::*;

  front_state_t st_r, st_nxt;
  logic        func_r;
  logic [63:0] key_r;
  logic [63:0] k1_r;
  logic [63:0] prod_r;
  logic [63:0] lo_pp_r;
  logic [63:0] h;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      FR_IDLE: if (in_valid) st_nxt = FR_MUL;
      FR_MUL:  st_nxt = FR_MIX;
      FR_MIX:  if (job_ready) st_nxt = FR_IDLE;
      default: st_nxt = FR_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (st_r == FR_IDLE);
    job_valid = (st_r == FR_MIX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= FR_IDLE;
    else st_r <= st_nxt;
  end

  // 64x64 low product split into 32x32 partial products, registered in FR_MUL and summed in FR_MIX
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r <= in_data.func;
      key_r  <= in_data.key;
      k1_r   <= in_data.key ^ {32'd0, in_data.key[63:32]};
    end
    if (st_r == FR_MUL) begin
      lo_pp_r <= 64'(k1_r[31:0] * MixMult[31:0]);
      prod_r  <= {32'(k1_r[31:0] * MixMult[63:32]) + 32'(k1_r[63:32] * MixMult[31:0]),
                  32'd0};
    end
  end

  always_comb begin
    logic [63:0] p;
    p = lo_pp_r + prod_r;
    h = p ^ {32'd0, p[63:32]};
    job.func  = func_r;
    job.key   = key_r;
    job.slot  = h[SlotAw-1:0];
    job.bword = (BloomWords > 1) ? h[BloomAw-1:0] : '0;
    job.bmask = (64'd1 << h[37:32]) | (64'd1 << h[45:40]) |
                (64'd1 << h[53:48]) | (64'd1 << h[61:56]);
  end
endmodule

// ----- sv/flpks_queue.sv -----
module flpks_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  flpks_pkg::job_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output flpks_pkg::job_t rd_data
);
  import flpks_pkg::*;

  localparam int Pw = $clog2(QueueDepth);
  job_t            mem_r [QueueDepth];
  logic [Pw-1:0]   wp_r, rp_r;
  logic [Pw:0]     cnt_r;
  logic            push, pop;

  assign wr_ready = (cnt_r != (Pw+1)'(QueueDepth));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (Pw+1)'(push) - (Pw+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end
endmodule

// ----- sv/flpks_back.sv -----
module flpks_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  flpks_pkg::job_t      job,
  output logic                 out_valid,
  input  logic                 out_ready,
  output flpks_pkg::out_word_t out_data
);
  import flpks_pkg::*;

  back_state_t st_r, st_nxt;

  logic [63:0]       slot_mem [SlotCount];
  logic [63:0]       bloom_mem [BloomWords];
  logic [SlotAw-1:0] clr_idx_r;

  job_t              job_r;
  logic [SlotAw-1:0] pidx_r;
  logic [SlotAw:0]   pcnt_r;
  logic [63:0]       slot_rd_r, bloom_rd_r;
  logic [CountW-1:0] count_r;
  logic [63:0]       min_r, max_r;
  logic              filt_r, hit_r, stop_r;
  out_word_t         res_r;
  logic              res_v_r;

  logic [63:0] slot_val, bloom_val;
  logic        is_empty, is_match, do_add, full;

  assign slot_val  = slot_rd_r;
  assign bloom_val = bloom_rd_r;
  assign is_empty  = (slot_val == 64'd0);
  assign is_match  = (slot_val == job_r.key);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_CLEAR: if (clr_idx_r == SlotAw'(SlotCount - 1)) st_nxt = BK_IDLE;
      BK_IDLE:  if (job_valid && !res_v_r) st_nxt = BK_BREAD;
      BK_BREAD: st_nxt = BK_PROBE;
      BK_PROBE: if (is_empty || is_match || pcnt_r == (SlotAw+1)'(SlotCount - 1))
                  st_nxt = BK_WRITE;
      BK_WRITE: st_nxt = BK_DONE;
      BK_DONE:  st_nxt = BK_IDLE;
      default:  st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    job_ready = (st_r == BK_IDLE) && !res_v_r;
    out_valid = res_v_r;
    out_data  = res_r;
  end

  // hit_r/stop_r describe the last probed slot
  assign full   = ({1'b0, count_r} >= FullLimit) || !stop_r;
  assign do_add = (job_r.func == FuncInsert) && (job_r.key != 64'd0) && !hit_r && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_CLEAR;
      clr_idx_r <= '0;
      res_v_r <= 1'b0;
      count_r <= '0;
      min_r <= '1;
      max_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == BK_CLEAR) clr_idx_r <= clr_idx_r + 1'b1;
      if (out_valid && out_ready) res_v_r <= 1'b0;
      if (st_r == BK_WRITE && do_add) begin
        count_r <= count_r + 1'b1;
        if (job_r.key < min_r) min_r <= job_r.key;
        if (job_r.key > max_r) max_r <= job_r.key;
      end
      if (st_r == BK_DONE) res_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      BK_IDLE: if (job_valid && !res_v_r) begin
        job_r  <= job;
        pidx_r <= job.slot;
        pcnt_r <= '0;
      end
      BK_PROBE: begin
        hit_r  <= is_match && !is_empty;
        stop_r <= is_empty || is_match;
        if (!(is_empty || is_match)) begin
          pidx_r <= pidx_r + 1'b1;
          pcnt_r <= pcnt_r + 1'b1;
        end
      end
      default: ;
    endcase
    if (st_r == BK_BREAD)
      filt_r <= !(job_r.key < min_r || job_r.key > max_r) &&
                ((bloom_val & job_r.bmask) == job_r.bmask);
    if (st_r == BK_DONE) begin
      res_r.present     <= hit_r && (job_r.key != 64'd0) &&
                           (job_r.func == FuncInsert || filt_r);
      res_r.filter_pass <= filt_r;
      res_r.entry_count <= count_r;
    end
    if (st_r == BK_WRITE) begin
      res_r.added      <= do_add;
      res_r.table_full <= (job_r.func == FuncInsert) && (job_r.key != 64'd0) &&
                          !hit_r && full;
    end
  end

  // memories: registered reads, addressed by probe index / bloom word
  always_ff @(posedge clk) begin
    logic [SlotAw-1:0] ra;
    ra = (st_r == BK_PROBE && !(is_empty || is_match)) ? pidx_r + 1'b1 : pidx_r;
    if (st_r == BK_IDLE) ra = job.slot;
    slot_rd_r <= slot_mem[ra];
    if (st_r == BK_CLEAR) slot_mem[clr_idx_r] <= 64'd0;
    else if (st_r == BK_WRITE && do_add) slot_mem[pidx_r] <= job_r.key;
  end

  always_ff @(posedge clk) begin
    bloom_rd_r <= bloom_mem[(st_r == BK_IDLE) ? job.bword : job_r.bword];
    if (st_r == BK_CLEAR)
      bloom_mem[clr_idx_r[BloomAw-1:0]] <= 64'd0;
    else if (st_r == BK_WRITE && do_add)
      bloom_mem[job_r.bword] <= bloom_val | job_r.bmask;
  end
endmodule

// ----- sv/filtered_linear_probe_key_set.sv -----
// channel | ports                         | payload
// input   | in_valid, in_ready, in_data   | in_word_t  (func, key)
// output  | out_valid, out_ready, out_data| out_word_t (present .. entry_count)
// The front hashes a key through FR_MUL and FR_MIX (32-bit partial-product multiply).
// The back steps a word through BK_BREAD, BK_PROBE, BK_WRITE and BK_DONE, and
// stays in BK_PROBE while it walks past occupied slots through the single
// slot-memory read port. It takes the next word only the cycle after its result is accepted.
// Reset starts a pass over every slot address that zeroes both memories; no word enters
// the back until it ends.
// A two-entry queue lets the front hash the next word while the back probes.
module filtered_linear_probe_key_set (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  flpks_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output flpks_pkg::out_word_t out_data
);
  import flpks_pkg::*;

  logic f_valid, f_ready, b_valid, b_ready;
  job_t f_job, b_job;

  flpks_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  flpks_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_job)
  );

  flpks_back u_back (
    .clk, .rst_n,
    .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
    .out_valid, .out_ready, .out_data
  );
endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import flpks_pkg::*;

  localparam int KeyPoolSize = 200;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  filtered_linear_probe_key_set uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // set state mirrored by the predictor
  logic [63:0]       slot_mirror [SlotCount];
  logic [63:0]       bloom_mirror[BloomWords];
  int unsigned       member_count;
  logic [63:0]       range_lo;
  logic [63:0]       range_hi;

  in_word_t          word_queue[$];
  out_word_t         result_queue[$];
  logic [63:0]       key_pool[$];
  int                mismatch_count;
  int                hold_cycles;
  bit                hold_req;
  bit                pause_req;
  bit                in_taken;
  int                burst_left;
  int                gap_left;

  function automatic void add_word(in_word_t w);
    word_queue = {word_queue, w};
  endfunction

  function automatic void add_result(out_word_t r);
    result_queue = {result_queue, r};
  endfunction

  function automatic void add_pool_key(logic [63:0] k);
    key_pool = {key_pool, k};
  endfunction

  function automatic logic [63:0] mix_hash(logic [63:0] k);
    logic [63:0] h;
    h = k ^ (k >> 32);
    h = h * MixMult;
    return h ^ (h >> 32);
  endfunction

  function automatic out_word_t predict_set_op(in_word_t w);
    out_word_t   r;
    logic [63:0] h;
    logic [63:0] mask;
    int          bw;
    int          idx;
    int          n;
    bit          hit;
    bit          filt;
    h    = mix_hash(w.key);
    mask = (64'd1 << h[37:32]) | (64'd1 << h[45:40]) | (64'd1 << h[53:48])
         | (64'd1 << h[61:56]);
    bw   = int'(h) & (BloomWords - 1);
    filt = !(w.key < range_lo || w.key > range_hi)
         && ((bloom_mirror[bw] & mask) == mask);
    idx  = int'(h) & (SlotCount - 1);
    hit  = 0;
    for (n = 0; n < SlotCount; n++) begin
      if (slot_mirror[idx] == 64'd0) break;
      if (slot_mirror[idx] == w.key) begin
        hit = (w.key != 0);
        break;
      end
      idx = (idx + 1) % SlotCount;
    end
    r = '0;
    r.filter_pass = filt;
    r.present = (w.key != 0) && hit;
    if (w.func == FuncLookup) begin
      r.present = filt && r.present;
    end else if (w.key != 0 && !r.present) begin
      if ((member_count + 1) * 10 >= SlotCount * 7 || slot_mirror[idx] != 0) begin
        r.table_full = 1;
      end else begin
        slot_mirror[idx] = w.key;
        member_count++;
        if (w.key < range_lo) range_lo = w.key;
        if (w.key > range_hi) range_hi = w.key;
        bloom_mirror[bw] |= mask;
        r.added = 1;
      end
    end
    r.entry_count = member_count[CountW-1:0];
    return r;
  endfunction

  function automatic logic [63:0] rand_key();
    logic [63:0] k;
    k = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: k = k >> $urandom_range(0, 63);
      1: k = ~(k >> $urandom_range(0, 63));
      default: ;
    endcase
    return k;
  endfunction

  function automatic in_word_t make_word(logic f, logic [63:0] k);
    in_word_t w;
    w.func = f;
    w.key  = k;
    return w;
  endfunction

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // predict each word at the edge that accepts it
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      add_result(predict_set_op(in_data));
      in_taken = 1;
    end
  end

  // driver: bursts and gaps, honors a pause request
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      in_data  <= '0;
      in_taken = 0;
    end else if (!in_valid || in_taken) begin
      in_taken = 0;
      if (gap_left > 0) gap_left--;
      if (!pause_req && gap_left == 0 && word_queue.size() > 0) begin
        in_valid <= 1;
        in_data  <= word_queue.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 20);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 0;
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
    end else if (hold_req && hold_cycles < 300) begin
      hold_cycles++;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    out_word_t expd;
    if (rst_n && out_valid && out_ready) begin
      if (result_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected word %p", out_data);
      end else begin
        expd = result_queue.pop_front();
        if (out_data !== expd) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %p actual %p", expd, out_data);
        end
      end
    end
  end

  initial begin
    int          i;
    logic [63:0] k;
    for (i = 0; i < SlotCount; i++) slot_mirror[i] = 0;
    for (i = 0; i < BloomWords; i++) bloom_mirror[i] = 0;
    member_count   = 0;
    range_lo       = '1;
    range_hi       = 0;
    mismatch_count = 0;
    hold_cycles    = 0;
    hold_req       = 0;
    pause_req      = 0;
    in_taken       = 0;
    burst_left     = 0;
    gap_left       = 0;
    rst_n          = 0;
    in_valid       = 0;
    in_data        = '0;
    out_ready      = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;

    // directed: empty set, key zero, extremes, repeats
    add_word(make_word(FuncLookup, 64'd5));
    add_word(make_word(FuncLookup, 64'd0));
    add_word(make_word(FuncInsert, 64'd0));
    add_word(make_word(FuncInsert, 64'd1));
    add_word(make_word(FuncInsert, '1));
    add_word(make_word(FuncInsert, 64'h8000_0000_0000_0000));
    add_word(make_word(FuncInsert, 64'd1));
    add_word(make_word(FuncLookup, 64'd1));
    add_word(make_word(FuncLookup, '1));
    add_word(make_word(FuncLookup, 64'd0));
    add_word(make_word(FuncLookup, 64'd2));
    add_word(make_word(FuncLookup, 64'h7fff_ffff_ffff_ffff));
    add_word(make_word(FuncInsert, 64'h5555_aaaa_5555_aaaa));
    add_word(make_word(FuncLookup, 64'h5555_aaaa_5555_aaaa));
    add_word(make_word(FuncInsert, 64'h0000_0001_0000_0000));
    wait (word_queue.size() == 0 && !in_valid && result_queue.size() == 0);

    // long receiver hold while the sender keeps offering
    for (i = 0; i < 40; i++)
      add_word(make_word(1'($urandom), rand_key()));
    hold_req = 1;
    wait (word_queue.size() == 0);
    wait (hold_cycles >= 300);
    hold_req = 0;

    // sender pause until drained
    pause_req = 1;
    wait (result_queue.size() == 0 && !in_valid);
    repeat (20) @(posedge clk);
    pause_req = 0;

    // push occupancy toward the limit with fresh keys, with some lookups mixed in
    for (i = 0; i < 720; i++) begin
      k = rand_key();
      if (key_pool.size() < KeyPoolSize) add_pool_key(k);
      if (key_pool.size() > 0 && $urandom_range(0, 9) == 0)
        add_word(make_word(1'($urandom), key_pool[$urandom_range(0, key_pool.size() - 1)]));
      else
        add_word(make_word(FuncInsert, k));
    end
    // then retry known keys and offer fresh ones, as lookups or inserts
    for (i = 0; i < 40; i++) begin
      if ($urandom_range(0, 3) == 0) k = rand_key();
      else k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      add_word(make_word(1'($urandom), k));
    end

    wait (word_queue.size() == 0);
    wait (!in_valid && result_queue.size() == 0);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && result_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
